// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the queue, included by spq_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CHECK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CHECK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- hw/rtl/spq_pkg.sv -----
`default_nettype none
package spq_pkg;
  localparam int CAPACITY = 32;
  localparam int ID_WIDTH = 32;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int PRIO_W   = 2;
  localparam int NUM_LVL  = 4;
  localparam int ENTRY_W  = ID_WIDTH + PRIO_W;

  localparam int IN_ID_W     = 32;
  localparam int OUT_ID_W    = 32;
  localparam int S_TDATA_W   = ((3 + IN_ID_W + 7) / 8) * 8;
  localparam int M_TDATA_W   = ((OUT_ID_W + PRIO_W + 7) / 8) * 8;

  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [ID_WIDTH-1:0] id_t;
  typedef logic [PRIO_W-1:0]   prio_t;
  typedef logic [2:0]          status_t;
  typedef logic [1:0]          op_t;

  localparam logic [2:0] MAX_PRIO = 3'd3;

  localparam op_t OP_INSERT    = 2'd0;
  localparam op_t OP_ATTEND    = 2'd1;
  localparam op_t OP_LIST_ALL  = 2'd2;
  localparam op_t OP_LIST_PRIO = 2'd3;

  localparam status_t STAT_OK       = 3'd0;
  localparam status_t STAT_BAD_PRIO = 3'd1;
  localparam status_t STAT_FULL     = 3'd2;
  localparam status_t STAT_EMPTY    = 3'd3;
  localparam status_t STAT_NONE     = 3'd4;

  typedef struct packed {
    status_t status;
    id_t     id;
    prio_t   prio;
    logic    last;
  } res_t;

  // Physical slot of logical position idx in the circular store.
  function automatic ptr_t phys(input ptr_t head, input cnt_t idx);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(head) + (CNT_W + 1)'(idx);
    if (s >= (CNT_W + 1)'(CAPACITY)) begin
      s = s - (CNT_W + 1)'(CAPACITY);
    end
    return s[PTR_W-1:0];
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/spq_ram.sv -----
`default_nettype none
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/spq_out.sv -----
`default_nettype none
module spq_out (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           load,
  input  wire spq_pkg::res_t                  res,
  output logic                                free,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // out_id, out_priority, zero fill
  output logic [spq_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  // status
  output logic [2:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);
  spq_pkg::res_t held;
  logic          valid;

  assign free = !valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_axis_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = spq_pkg::M_TDATA_W'({held.prio, spq_pkg::OUT_ID_W'(held.id)});
  assign m_axis_tuser  = held.status;
  assign m_axis_tlast  = held.last;
endmodule
`default_nettype wire

// ----- hw/rtl/spq_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"
module spq_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire spq_pkg::op_t                  in_op,
  input  wire logic [2:0]                    in_prio,
  input  wire logic [spq_pkg::IN_ID_W-1:0]   in_id,
  output logic                               wr_en,
  output spq_pkg::ptr_t                      wr_addr,
  output logic [spq_pkg::ENTRY_W-1:0]        wr_data,
  output spq_pkg::ptr_t                      rd_addr,
  input  wire logic [spq_pkg::ENTRY_W-1:0]   rd_data,
  output logic                               res_load,
  output spq_pkg::res_t                      res,
  input  wire logic                          out_free
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS    = 3'd1;
  localparam logic [2:0] S_INS_WR = 3'd2;
  localparam logic [2:0] S_RD     = 3'd3;
  localparam logic [2:0] S_DAT    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]     state;
  spq_pkg::op_t   op;
  spq_pkg::prio_t prio;
  spq_pkg::id_t   id;
  spq_pkg::ptr_t  head;
  spq_pkg::cnt_t  count;
  spq_pkg::cnt_t  lvl_cnt [spq_pkg::NUM_LVL];
  spq_pkg::cnt_t  idx;
  spq_pkg::cnt_t  end_idx;
  spq_pkg::cnt_t  pos;
  logic           more;

  spq_pkg::cnt_t         upto_sum;
  spq_pkg::cnt_t         below_sum;
  logic [spq_pkg::CNT_W+1:0] lvl_sum;
  spq_pkg::prio_t        rd_prio;
  logic                  is_last;

  assign in_ready = (state == S_IDLE);
  assign rd_prio  = rd_data[spq_pkg::ID_WIDTH +: spq_pkg::PRIO_W];
  assign is_last  = ((idx + spq_pkg::cnt_t'(1)) == end_idx);
  assign res_load = (state == S_EMIT) && out_free;

  // Entries stay grouped by level, so level counts give every boundary.
  always_comb begin
    upto_sum  = '0;
    below_sum = '0;
    lvl_sum   = '0;
    for (int l = 0; l < spq_pkg::NUM_LVL; l++) begin
      if (2'(l) <= in_prio[1:0]) begin
        upto_sum = upto_sum + lvl_cnt[l];
      end
      if (2'(l) < in_prio[1:0]) begin
        below_sum = below_sum + lvl_cnt[l];
      end
      lvl_sum = lvl_sum + (spq_pkg::CNT_W + 2)'(lvl_cnt[l]);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = spq_pkg::phys(head, idx);
    wr_data = rd_data;
    if (state == S_INS) begin
      rd_addr = spq_pkg::phys(head, idx - spq_pkg::cnt_t'(1));
    end else begin
      rd_addr = spq_pkg::phys(head, idx);
    end
    if (state == S_INS && idx == pos) begin
      wr_en   = 1'b1;
      wr_data = {prio, id};
    end else if (state == S_INS_WR) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      more  <= 1'b0;
      for (int l = 0; l < spq_pkg::NUM_LVL; l++) begin
        lvl_cnt[l] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op       <= in_op;
            prio     <= in_prio[1:0];
            id       <= spq_pkg::id_t'(in_id);
            more     <= 1'b0;
            res.id   <= '0;
            res.prio <= '0;
            res.last <= 1'b1;
            if (in_op == spq_pkg::OP_INSERT) begin
              if (in_prio > spq_pkg::MAX_PRIO) begin
                res.status <= spq_pkg::STAT_BAD_PRIO;
                state      <= S_EMIT;
              end else if (count == spq_pkg::cnt_t'(spq_pkg::CAPACITY)) begin
                res.status <= spq_pkg::STAT_FULL;
                state      <= S_EMIT;
              end else begin
                res.status <= spq_pkg::STAT_OK;
                idx        <= count;
                pos        <= upto_sum;
                state      <= S_INS;
              end
            end else if (count == '0) begin
              res.status <= spq_pkg::STAT_EMPTY;
              state      <= S_EMIT;
            end else if (in_op == spq_pkg::OP_ATTEND) begin
              res.status <= spq_pkg::STAT_OK;
              idx        <= '0;
              end_idx    <= spq_pkg::cnt_t'(1);
              state      <= S_RD;
            end else if (in_op == spq_pkg::OP_LIST_ALL) begin
              res.status <= spq_pkg::STAT_OK;
              idx        <= '0;
              end_idx    <= count;
              state      <= S_RD;
            end else if (in_prio > spq_pkg::MAX_PRIO) begin
              res.status <= spq_pkg::STAT_BAD_PRIO;
              state      <= S_EMIT;
            end else if (lvl_cnt[in_prio[1:0]] == '0) begin
              res.status <= spq_pkg::STAT_NONE;
              state      <= S_EMIT;
            end else begin
              res.status <= spq_pkg::STAT_OK;
              idx        <= below_sum;
              end_idx    <= below_sum + lvl_cnt[in_prio[1:0]];
              state      <= S_RD;
            end
          end
        end
        S_INS: begin
          if (idx == pos) begin
            count         <= count + spq_pkg::cnt_t'(1);
            lvl_cnt[prio] <= lvl_cnt[prio] + spq_pkg::cnt_t'(1);
            state         <= S_EMIT;
          end else begin
            state <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          idx   <= idx - spq_pkg::cnt_t'(1);
          state <= S_INS;
        end
        S_RD: begin
          state <= S_DAT;
        end
        S_DAT: begin
          res.status <= spq_pkg::STAT_OK;
          res.id     <= rd_data[spq_pkg::ID_WIDTH-1:0];
          res.prio   <= rd_prio;
          res.last   <= is_last;
          more       <= !is_last;
          if (op == spq_pkg::OP_ATTEND) begin
            head             <= spq_pkg::phys(head, spq_pkg::cnt_t'(1));
            count            <= count - spq_pkg::cnt_t'(1);
            lvl_cnt[rd_prio] <= lvl_cnt[rd_prio] - spq_pkg::cnt_t'(1);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (more) begin
              idx   <= idx + spq_pkg::cnt_t'(1);
              state <= S_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CHECK(a_count_bound, clk, rst, count <= spq_pkg::cnt_t'(spq_pkg::CAPACITY))
  `ASSERT_CHECK(a_level_sum, clk, rst, lvl_sum == (spq_pkg::CNT_W + 2)'(count))
  `ASSERT_CHECK(a_emit_hold, clk, rst, (state == S_EMIT && !out_free) |=> (state == S_EMIT))
  `ASSERT_CHECK(a_write_only_insert, clk, rst, wr_en |-> (state == S_INS || state == S_INS_WR))
endmodule
`default_nettype wire

// ----- hw/rtl/stable_priority_queue_unit.sv -----
// Steps: insert moves each entry of a higher level up one slot (read, then write), then writes
// the new entry and loads its status; attend and each listed entry take read, capture, load.
// Rejected or error requests load their answer straight from idle.
// One request at a time: ready returns the cycle after the last result is loaded, and a
// stalled output holds the sequence in place.
// Synchronous active-high reset empties the queue; the entry RAM is not cleared.
`default_nettype none
module stable_priority_queue_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // priority_req [2:0], entry_id [34:3], zero fill
  input  wire logic [spq_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // opcode
  input  wire logic [1:0]                   s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // out_id [31:0], out_priority [33:32], zero fill
  output logic [spq_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // status
  output logic [2:0]                        m_axis_tuser,
  output logic                              m_axis_tlast
);
  logic                            wr_en;
  spq_pkg::ptr_t                   wr_addr;
  logic [spq_pkg::ENTRY_W-1:0]     wr_data;
  spq_pkg::ptr_t                   rd_addr;
  logic [spq_pkg::ENTRY_W-1:0]     rd_data;
  logic                            res_load;
  spq_pkg::res_t                   res;
  logic                            out_free;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tuser),
    .in_prio  (s_axis_tdata[2:0]),
    .in_id    (s_axis_tdata[3 +: spq_pkg::IN_ID_W]),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .res_load (res_load),
    .res      (res),
    .out_free (out_free)
  );

  spq_ram #(
    .WIDTH (spq_pkg::ENTRY_W),
    .DEPTH (spq_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  spq_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (res_load),
    .res           (res),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );
endmodule
`default_nettype wire

// ----- tb/tb_stable_priority_queue_unit.sv -----
`timescale 1ns / 1ps
module tb_stable_priority_queue_unit;
  import spq_pkg::*;

  typedef struct {
    id_t   id;
    prio_t prio;
  } entry_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // priority_req [2:0], entry_id [34:3], zero fill
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  // opcode
  logic [1:0]           s_axis_tuser = OP_INSERT;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // out_id [31:0], out_priority [33:32], zero fill
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // status
  logic [2:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  // Our own copy of the queue contents, kept in service order.
  entry_t queued_entries[$];
  res_t   pending_answers[$];

  int error_count = 0;
  int checked_count = 0;
  int op_count[4] = '{0, 0, 0, 0};
  bit no_idle = 1'b0;
  int hold_len = 0;

  stable_priority_queue_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void expect_answer(status_t status, id_t id, prio_t prio, logic last);
    res_t r;
    r.status = status;
    r.id     = id;
    r.prio   = prio;
    r.last   = last;
    pending_answers.push_back(r);
  endfunction

  // Updates the queue copy for one accepted request and queues its answers.
  function automatic void predict_queue_answers(op_t op, logic [2:0] prio, id_t id);
    int     pos;
    int     found;
    entry_t e;
    if (op == OP_INSERT) begin
      if (prio > MAX_PRIO) begin
        expect_answer(STAT_BAD_PRIO, '0, '0, 1'b1);
      end else if (queued_entries.size() >= CAPACITY) begin
        expect_answer(STAT_FULL, '0, '0, 1'b1);
      end else begin
        // A new entry goes behind everything of its own or a more urgent level.
        pos = 0;
        while (pos < queued_entries.size() && queued_entries[pos].prio <= prio) pos++;
        e.id   = id;
        e.prio = prio[1:0];
        queued_entries.insert(pos, e);
        expect_answer(STAT_OK, '0, '0, 1'b1);
      end
    end else if (queued_entries.size() == 0) begin
      expect_answer(STAT_EMPTY, '0, '0, 1'b1);
    end else if (op == OP_ATTEND) begin
      e = queued_entries.pop_front();
      expect_answer(STAT_OK, e.id, e.prio, 1'b1);
    end else if (op == OP_LIST_ALL) begin
      foreach (queued_entries[i]) begin
        expect_answer(STAT_OK, queued_entries[i].id, queued_entries[i].prio,
                      i == queued_entries.size() - 1);
      end
    end else if (prio > MAX_PRIO) begin
      expect_answer(STAT_BAD_PRIO, '0, '0, 1'b1);
    end else begin
      found = 0;
      foreach (queued_entries[i]) begin
        if (queued_entries[i].prio == prio[1:0]) begin
          expect_answer(STAT_OK, queued_entries[i].id, queued_entries[i].prio, 1'b0);
          found++;
        end
      end
      if (found == 0) begin
        expect_answer(STAT_NONE, '0, '0, 1'b1);
      end else begin
        pending_answers[pending_answers.size() - 1].last = 1'b1;
      end
    end
  endfunction

  function automatic logic [2:0] rand_prio();
    if ($urandom_range(0, 9) == 0) begin
      return 3'($urandom_range(4, 7));
    end
    return 3'($urandom_range(0, 3));
  endfunction

  // Valid stays high after a transfer so back-to-back requests need no toggle.
  task automatic send_request(input op_t op, input logic [2:0] prio, input id_t id);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_TDATA_W - 35){1'b0}}, id, prio};
    do @(posedge clk); while (!s_axis_tready);
    predict_queue_answers(op, prio, id);
    op_count[op]++;
  endtask

  task automatic send_random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 42) begin
      send_request(OP_INSERT, rand_prio(), $urandom);
    end else if (r < 72) begin
      send_request(OP_ATTEND, 3'($urandom_range(0, 7)), $urandom);
    end else if (r < 82) begin
      send_request(OP_LIST_ALL, 3'($urandom_range(0, 7)), $urandom);
    end else begin
      send_request(OP_LIST_PRIO, rand_prio(), $urandom);
    end
  endtask

  task automatic wait_all_answered();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    send_request(OP_ATTEND, 3'd0, '0);
    send_request(OP_LIST_ALL, 3'd0, '0);
    send_request(OP_LIST_PRIO, 3'd0, '0);
    // On an empty queue the empty status wins over a bad level.
    send_request(OP_LIST_PRIO, 3'd7, '1);
    send_request(OP_INSERT, 3'd4, 32'h1234_5678);
    send_request(OP_INSERT, 3'd7, '1);
  endtask

  task automatic test_order_within_levels();
    send_request(OP_INSERT, 3'd3, 32'h0000_0000);
    send_request(OP_INSERT, 3'd0, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 3'd3, 32'h0000_0005);
    send_request(OP_INSERT, 3'd1, 32'hA5A5_A5A5);
    send_request(OP_INSERT, 3'd0, 32'h5A5A_5A5A);
    send_request(OP_LIST_ALL, 3'd0, '0);
    send_request(OP_LIST_PRIO, 3'd0, '0);
    send_request(OP_LIST_PRIO, 3'd1, '0);
    send_request(OP_LIST_PRIO, 3'd2, '0);
    send_request(OP_LIST_PRIO, 3'd3, '0);
    send_request(OP_LIST_PRIO, 3'd5, '0);
    send_request(OP_ATTEND, 3'd6, '1);
    send_request(OP_ATTEND, 3'd0, '0);
  endtask

  // Fill past capacity while the output is held off, so the input stalls too.
  task automatic test_full_and_backpressure();
    int n;
    hold_len = 200;
    n = CAPACITY + 2 - queued_entries.size();
    repeat (n) send_request(OP_INSERT, 3'($urandom_range(0, 3)), $urandom);
    send_request(OP_INSERT, 3'd5, $urandom);
    send_request(OP_LIST_ALL, 3'd0, '0);
    for (int p = 0; p < 4; p++) send_request(OP_LIST_PRIO, 3'(p), $urandom);
    wait_all_answered();
    repeat (12) send_request(OP_ATTEND, 3'($urandom_range(0, 7)), $urandom);
  endtask

  task automatic test_random_traffic();
    for (int chunk = 0; chunk < 10; chunk++) begin
      no_idle = (chunk % 4 == 3);
      repeat (25) send_random_request();
    end
    no_idle = 1'b0;
  endtask

  // Receiver: random stalls per result, plus a long hold-off when requested.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (hold_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 3);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      checked_count++;
      if (pending_answers.size() == 0) begin
        $error("unexpected result transfer: status %0d id %h", m_axis_tuser,
               m_axis_tdata[31:0]);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata[31:0] !== want.id) begin
          $error("out_id: expected %h, got %h", want.id, m_axis_tdata[31:0]);
          error_count++;
        end
        if (m_axis_tdata[33:32] !== want.prio) begin
          $error("out_priority: expected %0d, got %0d", want.prio, m_axis_tdata[33:32]);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_queue();
    test_order_within_levels();
    test_full_and_backpressure();
    test_random_traffic();
    wait_all_answered();
    repeat (200) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $error("%0d expected results never arrived", pending_answers.size());
      error_count++;
    end
    $display("Sent %0d inserts, %0d attends, %0d full listings and %0d level listings.",
             op_count[OP_INSERT], op_count[OP_ATTEND], op_count[OP_LIST_ALL],
             op_count[OP_LIST_PRIO]);
    $display("Checked %0d result transfers, including a full queue and a long output stall.",
             checked_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d results outstanding.", pending_answers.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_ram.sv
hw/rtl/spq_out.sv
hw/rtl/spq_ctrl.sv
hw/rtl/stable_priority_queue_unit.sv
tb/tb_stable_priority_queue_unit.sv
